// ===== hw/rtl/tlfg_pkg.sv =====
`timescale 1ns / 1ps

package tlfg_pkg;

	localparam int CountWidth = 4;
	localparam int TimeWidth = 32;
	localparam int WaitWidth = 16;

	localparam int InDataWidth = 40;
	localparam int OutDataWidth = 8;
	localparam int AddrWidth = 5;

	typedef logic [CountWidth-1:0] count_t;
	typedef logic [TimeWidth-1:0] time_t;
	typedef logic [WaitWidth-1:0] wait_t;

	localparam count_t DetectNeededReset = 4'd4;
	localparam count_t MissLimitReset = 4'd6;
	localparam count_t ConvergeNeededReset = 4'd5;
	localparam wait_t SettleWaitReset = 16'd10000;
	localparam wait_t FireSpacingReset = 16'd700;

	localparam logic [2:0] RegDetectNeeded = 3'd0;
	localparam logic [2:0] RegMissLimit = 3'd1;
	localparam logic [2:0] RegConvergeNeeded = 3'd2;
	localparam logic [2:0] RegSettleWait = 3'd3;
	localparam logic [2:0] RegFireSpacing = 3'd4;

	localparam logic [1:0] CmdNone = 2'd0;
	localparam logic [1:0] CmdStart = 2'd1;
	localparam logic [1:0] CmdUpdate = 2'd2;

	typedef struct packed {
		logic [1:0] tracker_command;
		logic fire;
		logic tracker_reset;
		logic stable;
	} result_t;

	function automatic count_t sat_inc(input count_t v);
		sat_inc = (v == {CountWidth{1'b1}}) ? v : count_t'(v + count_t'(1));
	endfunction

endpackage

// ===== hw/rtl/track_lock_fire_gate_top.sv =====
`timescale 1ns / 1ps

// Frame gate between a target detector, a tracker and a fire command. One item per camera
// frame enters on the slave stream; one result item per input leaves on the master stream.
// Each item is held in an input register and is then evaluated against the tracking
// state combinationally, the result landing in an output register, so an item can be
// accepted every cycle unless master back-pressure stalls the input register. The user
// sets thresholds and time windows through the APB port while idle; this is not enforced.
module track_lock_fire_gate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// target_seen, tracker_converged, tracker_diverged, fire_request, frame_time_ms[31:0], pad
	input  logic [tlfg_pkg::InDataWidth-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tracker_command[1:0], fire, tracker_reset, stable, pad
	output logic [tlfg_pkg::OutDataWidth-1:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [tlfg_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tlfg_pkg::count_t detect_needed_q;
	tlfg_pkg::count_t miss_limit_q;
	tlfg_pkg::count_t converge_needed_q;
	tlfg_pkg::wait_t settle_wait_q;
	tlfg_pkg::wait_t fire_spacing_q;

	logic cfg_we;
	logic [2:0] cfg_idx;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_needed_q <= tlfg_pkg::DetectNeededReset;
			miss_limit_q <= tlfg_pkg::MissLimitReset;
			converge_needed_q <= tlfg_pkg::ConvergeNeededReset;
			settle_wait_q <= tlfg_pkg::SettleWaitReset;
			fire_spacing_q <= tlfg_pkg::FireSpacingReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tlfg_pkg::RegDetectNeeded: detect_needed_q <= pwdata[3:0];
				tlfg_pkg::RegMissLimit: miss_limit_q <= pwdata[3:0];
				tlfg_pkg::RegConvergeNeeded: converge_needed_q <= pwdata[3:0];
				tlfg_pkg::RegSettleWait: settle_wait_q <= pwdata[15:0];
				tlfg_pkg::RegFireSpacing: fire_spacing_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			tlfg_pkg::RegDetectNeeded: prdata = {28'd0, detect_needed_q};
			tlfg_pkg::RegMissLimit: prdata = {28'd0, miss_limit_q};
			tlfg_pkg::RegConvergeNeeded: prdata = {28'd0, converge_needed_q};
			tlfg_pkg::RegSettleWait: prdata = {16'd0, settle_wait_q};
			tlfg_pkg::RegFireSpacing: prdata = {16'd0, fire_spacing_q};
			default: prdata = 32'd0;
		endcase
	end

	// Input register.
	logic valid_s1;
	logic seen_s1;
	logic conv_s1;
	logic div_s1;
	logic req_s1;
	tlfg_pkg::time_t time_s1;
	logic advance;

	assign advance = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			seen_s1 <= s_tdata[0];
			conv_s1 <= s_tdata[1];
			div_s1 <= s_tdata[2];
			req_s1 <= s_tdata[3];
			time_s1 <= s_tdata[35:4];
		end
	end

	// Tracking state.
	logic tracking_q;
	logic pending_q;
	tlfg_pkg::count_t detect_run_q;
	tlfg_pkg::count_t miss_run_q;
	tlfg_pkg::count_t conv_run_q;
	tlfg_pkg::time_t stable_since_q;
	tlfg_pkg::time_t last_fire_q;

	logic tracking_n;
	logic pending_n;
	tlfg_pkg::count_t detect_run_n;
	tlfg_pkg::count_t miss_run_n;
	tlfg_pkg::count_t conv_run_n;
	tlfg_pkg::time_t stable_since_n;
	tlfg_pkg::time_t last_fire_n;
	tlfg_pkg::result_t res;

	tlfg_pkg::count_t det_inc;
	tlfg_pkg::count_t miss_inc;
	tlfg_pkg::count_t conv_upd;
	tlfg_pkg::time_t since_sel;
	tlfg_pkg::time_t settle_diff;
	tlfg_pkg::time_t spacing_diff;
	logic pass;
	logic stab;
	logic drop;

	always_comb begin
		det_inc = tlfg_pkg::sat_inc(detect_run_q);
		miss_inc = tlfg_pkg::sat_inc(miss_run_q);
		conv_upd = conv_s1 ? tlfg_pkg::sat_inc(conv_run_q) : '0;
		pass = seen_s1 & (tracking_q | (det_inc >= detect_needed_q));
		stab = conv_upd >= converge_needed_q;
		since_sel = (stab && pending_q) ? time_s1 : stable_since_q;
		settle_diff = time_s1 - since_sel;
		spacing_diff = time_s1 - last_fire_q;

		tracking_n = tracking_q;
		pending_n = pending_q;
		detect_run_n = seen_s1 ? det_inc : '0;
		miss_run_n = seen_s1 ? '0 : miss_run_q;
		conv_run_n = conv_run_q;
		stable_since_n = stable_since_q;
		last_fire_n = last_fire_q;
		res = '{tracker_command: tlfg_pkg::CmdNone, fire: 1'b0, tracker_reset: 1'b0,
			stable: 1'b0};
		drop = 1'b0;

		priority if (pass && !tracking_q) begin
			res.tracker_command = tlfg_pkg::CmdStart;
			tracking_n = 1'b1;
		end else if (pass) begin
			res.tracker_command = tlfg_pkg::CmdUpdate;
			conv_run_n = conv_upd;
			if (stab) begin
				res.stable = 1'b1;
				stable_since_n = since_sel;
				pending_n = 1'b0;
				if (settle_diff > {16'd0, settle_wait_q} && req_s1 &&
						spacing_diff > {16'd0, fire_spacing_q}) begin
					res.fire = 1'b1;
					last_fire_n = time_s1;
				end
			end
			drop = div_s1;
		end else if (tracking_q) begin
			miss_run_n = miss_inc;
			drop = miss_inc >= miss_limit_q;
		end else begin
		end

		if (drop) begin
			res.tracker_reset = 1'b1;
			tracking_n = 1'b0;
			pending_n = 1'b1;
			detect_run_n = '0;
			miss_run_n = '0;
			conv_run_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			pending_q <= 1'b1;
			detect_run_q <= '0;
			miss_run_q <= '0;
			conv_run_q <= '0;
			stable_since_q <= '0;
			last_fire_q <= '0;
		end else if (advance) begin
			tracking_q <= tracking_n;
			pending_q <= pending_n;
			detect_run_q <= detect_run_n;
			miss_run_q <= miss_run_n;
			conv_run_q <= conv_run_n;
			stable_since_q <= stable_since_n;
			last_fire_q <= last_fire_n;
		end
	end

	// Output register.
	tlfg_pkg::result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (~m_tvalid | m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {3'd0, res_s2.stable, res_s2.tracker_reset, res_s2.fire,
		res_s2.tracker_command};

`ifndef ASSERT_OFF
	// A fire is only issued on a stable update frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!res_s2.fire ||
			(res_s2.stable && res_s2.tracker_command == tlfg_pkg::CmdUpdate)))
		else $error("fire without stable update");

	// A start frame never drops tracking or reports stability.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.tracker_command == tlfg_pkg::CmdStart) |->
			(!res_s2.tracker_reset && !res_s2.stable))
		else $error("start frame with reset or stable");

	// Tracking is only lost together with a reset result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tracking_q) |-> (m_tvalid && res_s2.tracker_reset))
		else $error("tracking dropped without reset result");

	// The state moves only when an item is evaluated.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> ($stable(tracking_q) && $stable(last_fire_q)))
		else $error("state changed without an item");
`endif

endmodule
